/* rtl/piecewise_linear_curve_table_core_macros.svh */
// Assertion macros used by the curve table top level.
`ifndef PIECEWISE_LINEAR_CURVE_TABLE_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_TABLE_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PLCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PLCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/plct_pkg.sv */
//==============================================================================
// plct_pkg
// Shared types and constants of the piecewise-linear curve table.
//==============================================================================
`default_nettype none
package plct_pkg;
    localparam int MaxPoints    = 16;
    localparam int FractionBits = 16;
    localparam int DataW        = 24;
    localparam int IdxW         = $clog2(MaxPoints);
    localparam int CntW         = $clog2(MaxPoints + 1);

    typedef logic [1:0] t_func;
    localparam t_func FUNC_LOOKUP = 2'd0;
    localparam t_func FUNC_INSERT = 2'd1;
    localparam t_func FUNC_ERASE  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    // One, saturated to the signed data range.
    localparam logic signed [DataW-1:0] OneVal =
        (FractionBits >= DataW - 1) ? {1'b0, {(DataW-1){1'b1}}}
                                    : DataW'(64'sd1 <<< FractionBits);

    typedef struct packed {
        logic [1:0]          func;
        logic signed [23:0]  key_in;
        logic signed [23:0]  value_in;
    } t_req;

    typedef struct packed {
        logic signed [23:0]  result_value;
        logic [1:0]          status;
        logic [4:0]          point_count;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;   // capture request, clear scan index
        logic scan_step;  // compare entry at scan index, advance
        logic shift_up;   // move entry idx-1 to idx, idx--
        logic shift_dn;   // move entry idx+1 to idx, idx++
        logic write_ins;  // write key/value at scan index, count++
        logic write_upd;  // overwrite value at scan index
        logic dec_count;  // count--
        logic rd_pair;    // read neighbors into operand registers
        logic div_start;  // set up the divider
        logic div_step;   // one quotient bit
        logic fin_interp; // form the interpolated result
        logic set_result; // load result from the lookup shortcut
        logic [1:0] res_sel;
        t_status    status;
    } t_cmd;

    localparam logic [1:0] RES_ZERO  = 2'd0;
    localparam logic [1:0] RES_FIRST = 2'd1;
    localparam logic [1:0] RES_HIT   = 2'd2;
    localparam logic [1:0] RES_LAST  = 2'd3;

    // Datapath status to the controller.
    typedef struct packed {
        logic       scan_done;  // scan index at count or key reached
        logic       hit;        // key at scan index equals request key
        logic       idx_zero;
        logic       idx_at_end; // scan index equals count
        logic       full;
        logic       count_zero;
        logic       count_one;
        logic       shift_up_done; // idx <= slot
        logic       shift_dn_done; // idx+1 >= count
        logic       div_done;
        t_func      func;
    } t_stat;
endpackage
`default_nettype wire

/* rtl/plct_if.sv */
//==============================================================================
// plct_req_if / plct_rsp_if
// Valid-ready channels for requests and responses.
//==============================================================================
`default_nettype none
interface plct_req_if;
    logic             valid;
    logic             ready;
    plct_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plct_rsp_if;
    logic             valid;
    logic             ready;
    plct_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/piecewise_linear_curve_table_core.sv */
// One transaction at a time: the scan steps over the keys below the request key, then a
// lookup between two points runs the divider, an insert moves each entry from its slot up
// by one before the write, and an erase moves each entry above the erased one down by one.
// The next request is taken in the cycle after the response is taken, and the 50-step
// restoring divider dominates an interpolated lookup.
// Reset (synchronous, active low) loads the points (0,0) and (1,1) and idles.
//==============================================================================
// piecewise_linear_curve_table_core
// Top level: sorted breakpoint table with linear interpolation lookups.
//==============================================================================
`default_nettype none
`include "piecewise_linear_curve_table_core_macros.svh"
module piecewise_linear_curve_table_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plct_req_if.sink   i_req,
    plct_rsp_if.source o_rsp
);
    import plct_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    t_rsp  w_rsp;

    // The controller sequences the scan, the entry shifts and the divider.
    plct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the table; the response is registered inside it and
    // stays stable while the transaction waits to be taken.
    plct_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_rsp   (w_rsp)
    );

    assign o_rsp.data = w_rsp;

    // The table never holds more points than it has room for.
    `PLCT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1,
        w_rsp.point_count <= 5'(MaxPoints), "point count exceeds table size")
    // No new request is taken while a response waits.
    `PLCT_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, o_rsp.valid,
        !i_req.ready, "request accepted while response pending")
    // A stalled response keeps its payload.
    `PLCT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready,
        $stable(o_rsp.data), "response changed while stalled")
endmodule
`default_nettype wire

/* rtl/plct_ctrl.sv */
//==============================================================================
// plct_ctrl
// Sequencer for search, shift, and division steps of one request.
//==============================================================================
`default_nettype none
module plct_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    input  wire plct_pkg::t_stat i_stat,
    output plct_pkg::t_cmd       o_cmd
);
    import plct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_INS_SHIFT, S_INS_WRITE, S_ERA_SHIFT,
        S_PAIR, S_DIV_INIT, S_DIV, S_FIN, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_status r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_DECIDE;
                else o_cmd.scan_step = 1'b1;
            end
            S_DECIDE: begin
                priority case (i_stat.func)
                    FUNC_LOOKUP: begin
                        o_cmd.set_result = 1'b1;
                        priority if (i_stat.count_zero) begin
                            o_cmd.res_sel = RES_ZERO; n_state = S_DONE;
                        end else if (i_stat.count_one) begin
                            o_cmd.res_sel = RES_FIRST; n_state = S_DONE;
                        end else if (i_stat.hit) begin
                            o_cmd.res_sel = RES_HIT; n_state = S_DONE;
                        end else if (i_stat.idx_zero) begin
                            o_cmd.res_sel = RES_FIRST; n_state = S_DONE;
                        end else if (i_stat.idx_at_end) begin
                            o_cmd.res_sel = RES_LAST; n_state = S_DONE;
                        end else begin
                            o_cmd.set_result = 1'b0;
                            n_state = S_PAIR;
                        end
                    end
                    FUNC_INSERT: begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.res_sel = RES_ZERO;
                        priority if (i_stat.hit) begin
                            o_cmd.write_upd = 1'b1; n_state = S_DONE;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL; n_state = S_DONE;
                        end else begin
                            n_state = S_INS_SHIFT;
                        end
                    end
                    FUNC_ERASE: begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.res_sel = RES_ZERO;
                        if (i_stat.hit) n_state = S_ERA_SHIFT;
                        else begin
                            n_status = ST_NOT_FOUND; n_state = S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.res_sel = RES_ZERO;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                if (i_stat.shift_up_done) n_state = S_INS_WRITE;
                else o_cmd.shift_up = 1'b1;
            end
            S_INS_WRITE: begin
                o_cmd.write_ins = 1'b1;
                n_state = S_DONE;
            end
            S_ERA_SHIFT: begin
                if (i_stat.shift_dn_done) begin
                    o_cmd.dec_count = 1'b1;
                    n_state = S_DONE;
                end else o_cmd.shift_dn = 1'b1;
            end
            S_PAIR: begin
                o_cmd.rd_pair = 1'b1;
                n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_FIN;
                else o_cmd.div_step = 1'b1;
            end
            S_FIN: begin
                o_cmd.fin_interp = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
endmodule
`default_nettype wire

/* rtl/plct_dp.sv */
//==============================================================================
// plct_dp
// Breakpoint storage, scan index, shifter and restoring divider.
//==============================================================================
`default_nettype none
module plct_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire plct_pkg::t_req   i_req,
    input  wire plct_pkg::t_cmd   i_cmd,
    output plct_pkg::t_stat       o_stat,
    output plct_pkg::t_rsp        o_rsp
);
    import plct_pkg::*;

    localparam int ProdW = 2 * DataW + 2;   // |dv * dx| < 2^50
    localparam int DivCntW = $clog2(ProdW + 1);

    // Entries are held in flip-flops, which the shifts move one at a time.
    logic signed [DataW-1:0] r_keys [MaxPoints];
    logic signed [DataW-1:0] r_vals [MaxPoints];
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_idx;
    logic [CntW-1:0] r_slot;
    t_func r_func;
    logic signed [DataW-1:0] r_key, r_val, r_result;
    logic signed [DataW-1:0] r_k0, r_k1, r_v0, r_v1;
    logic [ProdW-1:0] r_rem_num;  // magnitude of dividend, shifts out
    logic [ProdW-1:0] r_quo;
    logic [DataW:0]   r_den;
    logic [DataW+1:0] r_part;
    logic             r_neg;
    logic [DivCntW-1:0] r_dcnt;

    logic [IdxW-1:0] w_ix;
    logic [IdxW-1:0] w_ixm1;
    logic signed [DataW-1:0] w_key_at;
    logic signed [DataW:0]   w_dv, w_dk, w_dx;
    logic signed [2*DataW+1:0] w_prod;
    logic [DataW+1:0] w_trial;
    logic signed [ProdW:0] w_sum;
    logic signed [ProdW:0] w_q;

    assign w_ix     = r_idx[IdxW-1:0];
    assign w_ixm1   = IdxW'(r_idx - 1'b1);
    assign w_key_at = r_keys[w_ix];

    always_comb begin
        o_stat.scan_done     = (r_idx == r_count) || !(w_key_at < r_key);
        o_stat.hit           = (r_idx != r_count) && (w_key_at == r_key);
        o_stat.idx_zero      = (r_idx == '0);
        o_stat.idx_at_end    = (r_idx == r_count);
        o_stat.full          = (r_count >= CntW'(MaxPoints));
        o_stat.count_zero    = (r_count == '0);
        o_stat.count_one     = (r_count == CntW'(1));
        o_stat.shift_up_done = (r_idx <= r_slot);
        o_stat.shift_dn_done = ((r_idx + 1'b1) >= r_count);
        o_stat.div_done      = (r_dcnt == '0);
        o_stat.func          = r_func;
    end

    assign w_dv   = (DataW+1)'(r_v1) - (DataW+1)'(r_v0);
    assign w_dx   = (DataW+1)'(r_key) - (DataW+1)'(r_k0);
    assign w_dk   = (DataW+1)'(r_k1) - (DataW+1)'(r_k0);
    assign w_prod = w_dv * w_dx;
    assign w_trial = {r_part[DataW:0], r_rem_num[ProdW-1]} - {1'b0, r_den};
    assign w_q    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_sum  = w_q + (ProdW+1)'(r_v0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CntW'(2);
            r_idx   <= '0;
            r_dcnt  <= '0;
            r_keys[0] <= '0;
            r_vals[0] <= '0;
            r_keys[1] <= OneVal;
            r_vals[1] <= OneVal;
        end else begin
            if (i_cmd.load_req) begin
                r_func <= i_req.func;
                r_key  <= i_req.key_in;
                r_val  <= i_req.value_in;
                r_idx  <= '0;
            end
            if (i_cmd.scan_step) r_idx <= r_idx + 1'b1;
            if (i_cmd.set_result && i_cmd.res_sel == RES_ZERO && r_func == FUNC_INSERT) begin
                // Start the shift from the top of the table.
                r_slot <= r_idx;
                r_idx  <= r_count;
            end
            if (i_cmd.shift_up) begin
                r_keys[w_ix] <= r_keys[w_ixm1];
                r_vals[w_ix] <= r_vals[w_ixm1];
                r_idx <= r_idx - 1'b1;
            end
            if (i_cmd.shift_dn) begin
                r_keys[w_ix] <= r_keys[IdxW'(r_idx + 1'b1)];
                r_vals[w_ix] <= r_vals[IdxW'(r_idx + 1'b1)];
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.write_ins) begin
                r_keys[w_ix] <= r_key;
                r_vals[w_ix] <= r_val;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.write_upd) r_vals[w_ix] <= r_val;
            if (i_cmd.dec_count) r_count <= r_count - 1'b1;
            if (i_cmd.div_start) r_dcnt <= DivCntW'(ProdW);
            if (i_cmd.div_step)  r_dcnt <= r_dcnt - 1'b1;
        end
    end

    // Lookup operands, the bit-serial restoring divider and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pair) begin
            r_k0 <= r_keys[w_ixm1];
            r_v0 <= r_vals[w_ixm1];
            r_k1 <= r_keys[w_ix];
            r_v1 <= r_vals[w_ix];
        end
        if (i_cmd.div_start) begin
            r_neg     <= w_prod[2*DataW+1];
            r_rem_num <= ProdW'(w_prod[2*DataW+1] ? -w_prod : w_prod);
            r_den     <= w_dk[DataW:0];
            r_part    <= '0;
            r_quo     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_num <= {r_rem_num[ProdW-2:0], 1'b0};
            if (!w_trial[DataW+1]) begin
                r_part <= w_trial;
                r_quo  <= {r_quo[ProdW-2:0], 1'b1};
            end else begin
                r_part <= {r_part[DataW:0], r_rem_num[ProdW-1]};
                r_quo  <= {r_quo[ProdW-2:0], 1'b0};
            end
        end
        if (i_cmd.set_result) begin
            unique case (i_cmd.res_sel)
                RES_ZERO:  r_result <= '0;
                RES_FIRST: r_result <= r_vals[0];
                RES_HIT:   r_result <= r_vals[w_ix];
                RES_LAST:  r_result <= r_vals[IdxW'(r_count - 1'b1)];
                default:   r_result <= '0;
            endcase
        end
        if (i_cmd.fin_interp) begin
            if (w_sum > (ProdW+1)'(8388607))       r_result <= 24'sh7FFFFF;
            else if (w_sum < -(ProdW+1)'(8388608)) r_result <= 24'sh800000;
            else r_result <= w_sum[DataW-1:0];
        end
    end

    assign o_rsp.result_value = r_result;
    assign o_rsp.status       = i_cmd.status;
    assign o_rsp.point_count  = r_count;
endmodule
`default_nettype wire
